/* rtl/core/fwvp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fwvp_pkg
// Shared types and codes for the queue with value purge.
// ----------------------------------------------------------------------------
package fwvp_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W = 5;

  typedef logic [ACT_W-1:0] action_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam action_t ACT_ENQUEUE = 2'd0;
  localparam action_t ACT_DEQUEUE = 2'd1;
  localparam action_t ACT_PEEK = 2'd2;
  localparam action_t ACT_PURGE = 2'd3;

  localparam status_t STAT_OK = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PURGE_RD,
    S_PURGE_CMP
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/fifo_with_value_purge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_value_purge
// Ring-buffer queue of signed 32-bit values with enqueue, dequeue, peek and
// an order-keeping purge of all entries equal to a given value.
// ----------------------------------------------------------------------------
// channel  handshake          payload
// input    start / busy       in_action, in_value
// result   out_strobe         out_valid, out_value, out_status, out_occupancy
//
// Enqueue, dequeue and peek keep busy high through S_EXEC; a purge keeps it
// high through S_PURGE_RD and S_PURGE_CMP, one memory read and one compare
// per entry through the single read port and the shared ring-position adder.
// The result strobes for one cycle right after busy falls; a new item may be
// accepted in that same cycle. Synchronous reset empties the queue; stored
// entries are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module fifo_with_value_purge #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [fwvp_pkg::ACT_W-1:0]         in_action,
  input  wire logic signed [fwvp_pkg::VAL_W-1:0]  in_value,
  output logic                                    out_strobe,
  output logic                                    out_valid,
  output logic signed [fwvp_pkg::VAL_W-1:0]       out_value,
  output logic [fwvp_pkg::STAT_W-1:0]             out_status,
  output logic [fwvp_pkg::OCC_W-1:0]              out_occupancy
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

  logic [fwvp_pkg::VAL_W-1:0] mem [QUEUE_DEPTH];

  fwvp_pkg::state_t state_r, state_nxt;
  fwvp_pkg::action_t act_r;
  logic [fwvp_pkg::VAL_W-1:0] val_r;
  logic [fwvp_pkg::VAL_W-1:0] rd_data_r;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0] kept_r, kept_nxt;

  logic out_strobe_r, out_strobe_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [fwvp_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  fwvp_pkg::status_t out_status_r, out_status_nxt;

  logic accept;
  logic [CNT_W-1:0] ring_off;
  logic [SUM_W-1:0] ring_sum;
  logic [IDX_W-1:0] ring_pos;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [fwvp_pkg::VAL_W-1:0] wr_data;

  assign accept = start && !busy;

  // shared ring-position unit: (oldest + offset) mod depth
  assign ring_sum = SUM_W'(oldest_r) + SUM_W'(ring_off);
  assign ring_pos = (ring_sum >= DEPTH_S) ? IDX_W'(ring_sum - DEPTH_S) : IDX_W'(ring_sum);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fwvp_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_action == fwvp_pkg::ACT_PURGE) ? fwvp_pkg::S_PURGE_RD
                                                          : fwvp_pkg::S_EXEC;
        end
      end
      fwvp_pkg::S_EXEC: state_nxt = fwvp_pkg::S_IDLE;
      fwvp_pkg::S_PURGE_RD: begin
        state_nxt = (rd_cnt_r == count_r) ? fwvp_pkg::S_IDLE : fwvp_pkg::S_PURGE_CMP;
      end
      fwvp_pkg::S_PURGE_CMP: state_nxt = fwvp_pkg::S_PURGE_RD;
      default: state_nxt = fwvp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != fwvp_pkg::S_IDLE);
    ring_off = '0;
    rd_addr = oldest_r;
    wr_en = 1'b0;
    wr_addr = ring_pos;
    wr_data = val_r;
    oldest_nxt = oldest_r;
    count_nxt = count_r;
    rd_cnt_nxt = rd_cnt_r;
    kept_nxt = kept_r;
    out_strobe_nxt = 1'b0;
    out_valid_nxt = 1'b0;
    out_value_nxt = '0;
    out_status_nxt = fwvp_pkg::STAT_OK;
    case (state_r)
      fwvp_pkg::S_IDLE: begin
        rd_cnt_nxt = '0;
        kept_nxt = '0;
      end
      fwvp_pkg::S_EXEC: begin
        out_strobe_nxt = 1'b1;
        ring_off = (act_r == fwvp_pkg::ACT_ENQUEUE) ? count_r : CNT_W'(1);
        case (act_r)
          fwvp_pkg::ACT_ENQUEUE: begin
            if (count_r == DEPTH_C) begin
              out_status_nxt = fwvp_pkg::STAT_FULL;
            end else begin
              wr_en = 1'b1;
              wr_data = val_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          fwvp_pkg::ACT_DEQUEUE: begin
            if (count_r == '0) begin
              out_status_nxt = fwvp_pkg::STAT_EMPTY;
            end else begin
              out_valid_nxt = 1'b1;
              out_value_nxt = rd_data_r;
              oldest_nxt = ring_pos;
              count_nxt = count_r - CNT_W'(1);
            end
          end
          fwvp_pkg::ACT_PEEK: begin
            if (count_r == '0) begin
              out_status_nxt = fwvp_pkg::STAT_EMPTY;
            end else begin
              out_valid_nxt = 1'b1;
              out_value_nxt = rd_data_r;
            end
          end
          default: ;
        endcase
      end
      fwvp_pkg::S_PURGE_RD: begin
        ring_off = rd_cnt_r;
        rd_addr = ring_pos;
        if (rd_cnt_r == count_r) begin
          out_strobe_nxt = 1'b1;
          count_nxt = kept_r;
          if (kept_r == '0) begin
            oldest_nxt = '0;
          end
        end
      end
      fwvp_pkg::S_PURGE_CMP: begin
        ring_off = kept_r;
        rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        if (rd_data_r != val_r) begin
          wr_en = 1'b1;
          wr_data = rd_data_r;
          kept_nxt = kept_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      val_r <= in_value;
    end
    rd_cnt_r <= rd_cnt_nxt;
    kept_r <= kept_nxt;
    out_valid_r <= out_valid_nxt;
    out_value_r <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fwvp_pkg::S_IDLE;
      oldest_r <= '0;
      count_r <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oldest_r <= oldest_nxt;
      count_r <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_status = out_status_r;
  assign out_occupancy = fwvp_pkg::OCC_W'(count_r);

endmodule
`default_nettype wire
